>>> rtl/h264d_pkg.sv
// Shared types and constants for the H.264 RTP depacketizer.
// No dependencies; used by h264d_step and h264_rtp_depacketizer_unit.
package h264d_pkg;

   // codec_mode register values
   localparam logic [1:0] MODE_H264  = 2'd0;
   localparam logic [1:0] MODE_MPEG4 = 2'd1;

   // register index of codec_mode
   localparam logic REG_CODEC_MODE = 1'b0;

   // NAL unit types that steer the parse
   localparam logic [4:0] NAL_IDR    = 5'd5;
   localparam logic [4:0] NAL_STAP_A = 5'd24;
   localparam logic [4:0] NAL_STAP_B = 5'd25;
   localparam logic [4:0] NAL_FU_A   = 5'd28;
   localparam logic [4:0] NAL_FU_B   = 5'd29;

   localparam logic [7:0] NRI_MASK     = 8'hE0;
   localparam logic [7:0] MPEG4_VOL    = 8'h20;
   localparam logic [23:0] RECENT_INIT = 24'hFFFFFF;
   localparam logic [23:0] SC_TAIL     = 24'h000001;
   localparam logic [1:0]  DON_BYTES   = 2'd2;

   localparam int MAX_WORDS = 5;   // start code plus one header byte

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_COPY,
      PH_FUHDR,
      PH_SKIP,
      PH_LENHI,
      PH_LENLO,
      PH_UNIT,
      PH_DROP
   } phase_type;

   // what one payload byte puts on the stream
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_BYTE,      // one byte
      EMIT_SC,        // 00 00 00 01
      EMIT_SC_BYTE    // 00 00 00 01 then one byte
   } emit_kind_type;

   typedef struct packed {
      phase_type    phase;
      logic [7:0]   held_hdr;
      logic [1:0]   skip_cnt;
      logic [15:0]  unit_rem;
      logic [7:0]   len_hi;
      logic         idr_seen;
      logic [23:0]  recent;
      logic         mp4_key;
   } dep_state_type;

   typedef struct packed {
      emit_kind_type kind;
      logic [7:0]    value;
      logic          frame_end;
      logic          key;
   } emit_type;

endpackage

>>> rtl/h264_rtp_depacketizer_unit.sv
// Top level of the H.264 RTP depacketizer: input register, parser state,
// result word buffer and APB-style register port. Depends on h264d_pkg, h264d_step.
//
// Use:
//  - req_*: one RTP payload byte per word, with bytes left in its packet
//    (1 = last byte) and the packet's marker bit. Taken when req_valid is
//    high and req_stall is low.
//  - rsp_*: rebuilt Annex B stream, one byte per word. A packet byte yields
//    zero to five words (start code 00 00 00 01 plus header for a new NAL).
//    rsp_last_result tags the last word of a payload byte; rsp_frame_end
//    with rsp_key_frame closes a frame, on a bare word (byte_valid 0) when
//    the closing byte adds no stream data.
//  - psel/penable/pwrite/paddr/pwdata: codec_mode at address 0. Write it
//    only while the block is idle.
// Timing: a payload byte passes the input register, then the result buffer,
// before its first word is on rsp_*. Throughput is one payload byte per
// cycle while each gives at most one word and rsp_stall stays low; a byte
// giving n words holds the result buffer until all n have drained, since
// the buffer drains one word per cycle while rsp_stall is low.
// Reset (synchronous, active high) empties both stages, returns the parser
// to the first-byte phase, clears key tracking and sets codec_mode to 0.
// A stalled receiver freezes the buffer; one more byte waits in the input
// register, after which req_stall goes high.
module h264_rtp_depacketizer_unit
   import h264d_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // payload in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic [11:0] req_bytes_left,
   input  logic        req_frame_marker,
   // stream out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_end,
   output logic        rsp_key_frame,
   output logic        rsp_last_result,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---------------- register port ----------------
   logic [1:0] mode_ff, mode_in;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && paddr[2] == REG_CODEC_MODE) mode_in = pwdata[1:0];
   end

   assign prdata = (paddr[2] == REG_CODEC_MODE) ? {30'b0, mode_ff} : 32'b0;

   // ---------------- input register ----------------
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [11:0] in_left_ff;
   logic        in_marker_ff;
   logic        req_take;
   logic        advance;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   // ---------------- parser ----------------
   dep_state_type st_ff, st_in, st_step;
   emit_type      emit;

   h264d_step #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_step (
      .cur          (st_ff),
      .codec_mode   (mode_ff),
      .payload_byte (in_byte_ff),
      .bytes_left   (in_left_ff),
      .frame_marker (in_marker_ff),
      .nxt          (st_step),
      .emit         (emit)
   );

   assign st_in = advance ? st_step : st_ff;

   // ---------------- result buffer ----------------
   // Words sit left aligned in a short shift line; slot 0 drives rsp_out_byte.
   logic       out_valid_ff, out_valid_in;
   logic [7:0] words_ff [MAX_WORDS];
   logic [7:0] words_in [MAX_WORDS];
   logic [2:0] rem_ff, rem_in;
   logic       fe_ff, fe_in;
   logic       key_ff, key_in;
   logic       bv_ff, bv_in;
   logic       rsp_take;
   logic       last_word;

   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign last_word = (rem_ff == 3'd1);
   assign advance   = in_valid_ff && (!out_valid_ff || (rsp_take && last_word));

   always_comb begin
      out_valid_in = out_valid_ff;
      words_in     = words_ff;
      rem_in       = rem_ff;
      fe_in        = fe_ff;
      key_in       = key_ff;
      bv_in        = bv_ff;
      if (advance) begin
         fe_in  = emit.frame_end;
         key_in = emit.key;
         bv_in  = 1'b1;
         for (int i = 0; i < MAX_WORDS; i++) words_in[i] = 8'h00;
         case (emit.kind)
            EMIT_BYTE: begin
               words_in[0] = emit.value;
               rem_in      = 3'd1;
            end
            EMIT_SC: begin
               words_in[3] = 8'h01;
               rem_in      = 3'd4;
            end
            EMIT_SC_BYTE: begin
               words_in[3] = 8'h01;
               words_in[4] = emit.value;
               rem_in      = 3'd5;
            end
            default: begin
               // bare frame-end word, or nothing at all
               bv_in  = 1'b0;
               rem_in = 3'd1;
            end
         endcase
         out_valid_in = (emit.kind != EMIT_NONE) || emit.frame_end;
      end else if (rsp_take) begin
         if (last_word) begin
            out_valid_in = 1'b0;
         end else begin
            for (int i = 0; i < MAX_WORDS - 1; i++) words_in[i] = words_ff[i + 1];
            rem_in = rem_ff - 3'd1;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = words_ff[0];
   assign rsp_byte_valid  = bv_ff;
   assign rsp_last_result = last_word;
   assign rsp_frame_end   = fe_ff && last_word;
   assign rsp_key_frame   = fe_ff && key_ff && last_word;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_H264;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         rem_ff          <= 3'd1;
         st_ff.phase     <= PH_FIRST;
         st_ff.held_hdr  <= 8'h00;
         st_ff.skip_cnt  <= 2'd0;
         st_ff.unit_rem  <= 16'd0;
         st_ff.len_hi    <= 8'h00;
         st_ff.idr_seen  <= 1'b0;
         st_ff.recent    <= RECENT_INIT;
         st_ff.mp4_key   <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
         st_ff        <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff   <= req_payload_byte;
         in_left_ff   <= req_bytes_left;
         in_marker_ff <= req_frame_marker;
      end
      words_ff <= words_in;
      fe_ff    <= fe_in;
      key_ff   <= key_in;
      bv_ff    <= bv_in;
   end

   // ---------------- assertions ----------------
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall high with empty input register");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (rem_ff != 3'd0 && rem_ff <= 3'(MAX_WORDS)))
      else $error("result buffer word count out of range");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("buffers not empty after reset");

   a_bare_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_frame_end && rsp_last_result))
      else $error("bare word without frame end");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rem_ff)))
      else $error("result buffer moved while stalled");

endmodule

>>> rtl/h264d_step.sv
// Next-state and stream-byte logic for one payload byte.
// Depends on h264d_pkg.
module h264d_step
   import h264d_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  dep_state_type cur,
   input  logic [1:0]    codec_mode,
   input  logic [7:0]    payload_byte,
   input  logic [11:0]   bytes_left,
   input  logic          frame_marker,
   output dep_state_type nxt,
   output emit_type      emit
);

   logic          pkt_end;
   logic [11:0]   bl_sat;
   logic [11:0]   avail;
   logic [15:0]   len_raw;
   logic [15:0]   len_clamp;
   logic [4:0]    nal_type;
   logic [4:0]    held_type;
   logic [7:0]    fu_hdr;
   logic [1:0]    skip_dec;
   logic [15:0]   unit_dec;
   dep_state_type parse;
   emit_kind_type kind;
   logic [7:0]    value;
   logic [23:0]   recent_new;
   logic          mp4_new;
   logic          key;

   assign pkt_end   = (bytes_left <= 12'd1);
   assign bl_sat    = ({4'b0, bytes_left} > 16'(MAX_PACKET_BYTES)) ?
                      12'(MAX_PACKET_BYTES) : bytes_left;
   assign avail     = (bl_sat == 12'd0) ? 12'd0 : bl_sat - 12'd1;
   assign len_raw   = {cur.len_hi, payload_byte};
   assign len_clamp = (len_raw > {4'b0, avail}) ? {4'b0, avail} : len_raw;
   assign nal_type  = payload_byte[4:0];
   assign held_type = cur.held_hdr[4:0];
   assign fu_hdr    = (cur.held_hdr & NRI_MASK) | {3'b0, payload_byte[4:0]};
   assign skip_dec  = (cur.skip_cnt != 2'd0) ? cur.skip_cnt - 2'd1 : cur.skip_cnt;
   assign unit_dec  = (cur.unit_rem != 16'd0) ? cur.unit_rem - 16'd1 : cur.unit_rem;

   // parser next state (H.264 mode only; other modes leave it alone)
   always_comb begin
      parse = cur;
      if (codec_mode == MODE_H264) begin
         case (cur.phase)
            PH_FIRST: begin
               parse.held_hdr = payload_byte;
               if (nal_type inside {[5'd1:5'd23]}) begin
                  if (nal_type == NAL_IDR) parse.idr_seen = 1'b1;
                  parse.phase = PH_COPY;
               end else if (nal_type == NAL_STAP_A) begin
                  parse.phase = PH_LENHI;
               end else if (nal_type == NAL_STAP_B) begin
                  parse.skip_cnt = DON_BYTES;
                  parse.phase    = PH_SKIP;
               end else if (nal_type == NAL_FU_A || nal_type == NAL_FU_B) begin
                  parse.phase = PH_FUHDR;
               end else begin
                  parse.phase = PH_COPY;
               end
            end
            PH_COPY: ;
            PH_FUHDR: begin
               if (payload_byte[7] && payload_byte[4:0] == NAL_IDR)
                  parse.idr_seen = 1'b1;
               if (held_type == NAL_FU_B) begin
                  parse.skip_cnt = DON_BYTES;
                  parse.phase    = PH_SKIP;
               end else begin
                  parse.phase = PH_COPY;
               end
            end
            PH_SKIP: begin
               parse.skip_cnt = skip_dec;
               if (skip_dec == 2'd0)
                  parse.phase = (held_type == NAL_FU_B) ? PH_COPY : PH_LENHI;
            end
            PH_LENHI: begin
               if (bl_sat > 12'd2) begin
                  parse.len_hi = payload_byte;
                  parse.phase  = PH_LENLO;
               end else begin
                  parse.phase = PH_DROP;
               end
            end
            PH_LENLO: begin
               parse.unit_rem = len_clamp;
               parse.phase    = (len_clamp == 16'd0) ? PH_LENHI : PH_UNIT;
            end
            PH_UNIT: begin
               parse.unit_rem = unit_dec;
               if (unit_dec == 16'd0) parse.phase = PH_LENHI;
            end
            PH_DROP: ;
            default: ;
         endcase
      end
   end

   // stream bytes for this payload byte
   always_comb begin
      kind  = EMIT_NONE;
      value = payload_byte;
      if (codec_mode != MODE_H264) begin
         kind = EMIT_BYTE;
      end else begin
         case (cur.phase)
            PH_FIRST: begin
               if (nal_type inside {[5'd1:5'd23]})
                  kind = EMIT_SC_BYTE;
               else if (nal_type inside {NAL_STAP_A, NAL_STAP_B, NAL_FU_A, NAL_FU_B})
                  kind = EMIT_NONE;
               else
                  kind = EMIT_BYTE;
            end
            PH_COPY:  kind = EMIT_BYTE;
            PH_FUHDR: begin
               value = fu_hdr;
               kind  = payload_byte[7] ? EMIT_SC_BYTE : EMIT_NONE;
            end
            PH_LENLO: kind = EMIT_SC;
            PH_UNIT:  kind = EMIT_BYTE;
            default:  kind = EMIT_NONE;
         endcase
      end
   end

   // history of the last three stream bytes and the MPEG-4 VOL match
   always_comb begin
      recent_new = cur.recent;
      mp4_new    = cur.mp4_key;
      case (kind)
         EMIT_BYTE: begin
            if (value == MPEG4_VOL && cur.recent == SC_TAIL) mp4_new = 1'b1;
            recent_new = {cur.recent[15:0], value};
         end
         EMIT_SC: recent_new = SC_TAIL;
         EMIT_SC_BYTE: begin
            if (value == MPEG4_VOL) mp4_new = 1'b1;
            recent_new = {SC_TAIL[15:0], value};
         end
         default: ;
      endcase
   end

   always_comb begin
      case (codec_mode)
         MODE_H264:  key = parse.idr_seen;
         MODE_MPEG4: key = mp4_new;
         default:    key = 1'b1;
      endcase
   end

   always_comb begin
      nxt         = parse;
      nxt.recent  = recent_new;
      nxt.mp4_key = mp4_new;
      if (pkt_end) nxt.phase = PH_FIRST;
      if (pkt_end && frame_marker) begin
         nxt.idr_seen = 1'b0;
         nxt.mp4_key  = 1'b0;
         nxt.recent   = RECENT_INIT;
      end
      emit.kind      = kind;
      emit.value     = value;
      emit.frame_end = pkt_end && frame_marker;
      emit.key       = key;
   end

endmodule

>>> test/h264_rtp_depacketizer_checker.sv
// Scoreboard for the H.264 RTP depacketizer: predicts the stream words of every
// accepted payload word and compares them with the result channel.
// Depends on h264d_pkg; instantiated by testbench beside the block.
module h264_rtp_depacketizer_checker
   import h264d_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic [11:0] req_bytes_left,
   input  logic        req_frame_marker,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_byte_valid,
   input  logic        rsp_frame_end,
   input  logic        rsp_key_frame,
   input  logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          words_open,
   output int          mismatch_count
);

   localparam logic [4:0] NAL_SINGLE_FIRST = 5'd1;
   localparam logic [4:0] NAL_SINGLE_LAST  = 5'd23;
   localparam logic [2:0] MODE_ADDR        = {REG_CODEC_MODE, 2'b00};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      logic       key_frame;
      logic       last_result;
   } stream_word_type;

   // predictor state
   logic [1:0]      codec_mode;
   phase_type       phase;
   logic [7:0]      nal_hdr;
   logic [1:0]      don_left;
   logic [15:0]     unit_left;
   logic [7:0]      len_msb;
   logic            idr_flag;
   logic            vol_flag;
   logic [23:0]     tail3;

   stream_word_type step_words[$];      // words of the payload word in hand
   stream_word_type stream_expected[$]; // words not yet seen on rsp
   int              errors = 0;

   function automatic void put_byte(input logic [7:0] b);
      stream_word_type w;
      if (step_words.size() >= MAX_WORDS)
         return;
      if (b == MPEG4_VOL && tail3 == SC_TAIL)
         vol_flag = 1'b1;
      tail3 = {tail3[15:0], b};
      w = '{b, 1'b1, 1'b0, 1'b0, 1'b0};
      step_words.insert(step_words.size(), w);
   endfunction

   function automatic void put_start_code();
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h01);
   endfunction

   function automatic void parse_h264(input logic [7:0] b, input int unsigned room);
      logic [7:0]  hdr;
      int unsigned len;
      int unsigned avail;
      case (phase)
         PH_FIRST: begin
            nal_hdr = b;
            if (b[4:0] >= NAL_SINGLE_FIRST && b[4:0] <= NAL_SINGLE_LAST) begin
               if (b[4:0] == NAL_IDR)
                  idr_flag = 1'b1;
               put_start_code();
               put_byte(b);
               phase = PH_COPY;
            end else if (b[4:0] == NAL_STAP_A) begin
               phase = PH_LENHI;
            end else if (b[4:0] == NAL_STAP_B) begin
               don_left = DON_BYTES;
               phase = PH_SKIP;
            end else if (b[4:0] == NAL_FU_A || b[4:0] == NAL_FU_B) begin
               phase = PH_FUHDR;
            end else begin
               put_byte(b);
               phase = PH_COPY;
            end
         end
         PH_COPY: put_byte(b);
         PH_FUHDR: begin
            // start bit: rebuild the header from indicator NRI and FU type
            if (b[7]) begin
               hdr = (nal_hdr & NRI_MASK) | {3'b000, b[4:0]};
               if (hdr[4:0] == NAL_IDR)
                  idr_flag = 1'b1;
               put_start_code();
               put_byte(hdr);
            end
            if (nal_hdr[4:0] == NAL_FU_B) begin
               don_left = DON_BYTES;
               phase = PH_SKIP;
            end else begin
               phase = PH_COPY;
            end
         end
         PH_SKIP: begin
            if (don_left != 2'd0)
               don_left = don_left - 2'd1;
            if (don_left == 2'd0)
               phase = (nal_hdr[4:0] == NAL_FU_B) ? PH_COPY : PH_LENHI;
         end
         PH_LENHI: begin
            if (room > 2) begin
               len_msb = b;
               phase = PH_LENLO;
            end else begin
               phase = PH_DROP;
            end
         end
         PH_LENLO: begin
            len = {len_msb, b};
            avail = (room > 0) ? room - 1 : 0;
            if (len > avail)
               len = avail;
            put_start_code();
            unit_left = 16'(len);
            phase = (len == 0) ? PH_LENHI : PH_UNIT;
         end
         PH_UNIT: begin
            put_byte(b);
            if (unit_left != 16'd0)
               unit_left = unit_left - 16'd1;
            if (unit_left == 16'd0)
               phase = PH_LENHI;
         end
         default: ;
      endcase
   endfunction

   function automatic void take_payload(input logic [7:0] b, input logic [11:0] left,
                                        input logic marker);
      int unsigned     room;
      logic            packet_done;
      logic            key;
      stream_word_type w;
      step_words.delete();
      packet_done = (left <= 12'd1);
      room = (left > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : left;
      if (codec_mode == MODE_H264)
         parse_h264(b, room);
      else
         put_byte(b);
      if (packet_done)
         phase = PH_FIRST;
      if (packet_done && marker) begin
         if (codec_mode == MODE_H264)
            key = idr_flag;
         else if (codec_mode == MODE_MPEG4)
            key = vol_flag;
         else
            key = 1'b1;
         if (step_words.size() == 0) begin
            w = '0;
            step_words.insert(0, w);
         end
         w = step_words.pop_back();
         w.frame_end = 1'b1;
         w.key_frame = key;
         step_words.insert(step_words.size(), w);
         idr_flag = 1'b0;
         vol_flag = 1'b0;
         tail3 = RECENT_INIT;
      end
      if (step_words.size() != 0) begin
         w = step_words.pop_back();
         w.last_result = 1'b1;
         step_words.insert(step_words.size(), w);
      end
      foreach (step_words[i])
         stream_expected.insert(stream_expected.size(), step_words[i]);
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   task automatic check_word();
      stream_word_type want;
      if (stream_expected.size() == 0) begin
         report_mismatch("word with none expected, out_byte", rsp_out_byte, 8'h00);
      end else begin
         want = stream_expected.pop_front();
         if (rsp_out_byte != want.out_byte)
            report_mismatch("out_byte", rsp_out_byte, want.out_byte);
         if (rsp_byte_valid != want.byte_valid)
            report_mismatch("byte_valid", {7'd0, rsp_byte_valid}, {7'd0, want.byte_valid});
         if (rsp_frame_end != want.frame_end)
            report_mismatch("frame_end", {7'd0, rsp_frame_end}, {7'd0, want.frame_end});
         if (rsp_key_frame != want.key_frame)
            report_mismatch("key_frame", {7'd0, rsp_key_frame}, {7'd0, want.key_frame});
         if (rsp_last_result != want.last_result)
            report_mismatch("last_result", {7'd0, rsp_last_result}, {7'd0, want.last_result});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         codec_mode = MODE_H264;
         phase = PH_FIRST;
         nal_hdr = 8'h00;
         don_left = 2'd0;
         unit_left = 16'd0;
         len_msb = 8'h00;
         idr_flag = 1'b0;
         vol_flag = 1'b0;
         tail3 = RECENT_INIT;
         stream_expected.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
            codec_mode = pwdata[1:0];
         if (req_valid && !req_stall)
            take_payload(req_payload_byte, req_bytes_left, req_frame_marker);
         if (rsp_valid && !rsp_stall)
            check_word();
      end
      words_open <= stream_expected.size();
      mismatch_count <= errors;
   end

endmodule

>>> test/testbench.sv
// Testbench top for h264_rtp_depacketizer_unit: clock, reset, codec_mode writes,
// RTP payload stimulus and random stalls on the stream side.
// Depends on h264d_pkg, the RTL and h264_rtp_depacketizer_checker.
module testbench;
   import h264d_pkg::*;

   localparam int MAX_PACKET_BYTES = 2048;
   localparam int ITEM_TARGET      = 280;     // ~35 directed words, the rest random
   localparam int MAX_GAP          = 19;      // per-word idle draw, both sides
   localparam int RX_HOLD_CYCLES   = 150;     // long stream-side hold-off
   localparam int DRAIN_CYCLES     = 8;       // two pipeline stages plus margin
   localparam int CYCLE_LIMIT      = 400000;

   localparam logic [2:0] MODE_ADDR     = {REG_CODEC_MODE, 2'b00};
   localparam logic [1:0] MODE_PASS     = 2'd2;
   localparam logic [1:0] MODE_PASS_ALT = 2'd3;   // undocumented value, acts as pass

   // NAL types that the parser copies unchanged
   localparam logic [4:0] NAL_UNSPEC0 = 5'd0;
   localparam logic [4:0] NAL_MTAP16  = 5'd26;
   localparam logic [4:0] NAL_MTAP24  = 5'd27;
   localparam logic [4:0] NAL_RSVD30  = 5'd30;
   localparam logic [4:0] NAL_RSVD31  = 5'd31;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_payload_byte = 8'h00;
   logic [11:0] req_bytes_left   = 12'd1;
   logic        req_frame_marker = 1'b0;
   logic        rsp_stall        = 1'b0;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [2:0]  paddr            = 3'd0;
   logic [31:0] pwdata           = 32'd0;

   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_frame_end;
   logic        rsp_key_frame;
   logic        rsp_last_result;
   logic [31:0] prdata;
   logic        pready;

   int          words_open;
   int          mismatch_count;

   // stimulus bookkeeping
   logic [7:0]  pkt[$];          // payload of the packet being built
   int          items_sent = 0;
   bit          tx_quiet = 1'b0; // sender: no idle cycles
   bit          rx_quiet = 1'b0; // receiver: no stall cycles
   bit          rx_hold_req = 1'b0;
   int          cycle_count = 0;

   h264_rtp_depacketizer_unit #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload_byte(req_payload_byte),
      .req_bytes_left(req_bytes_left),
      .req_frame_marker(req_frame_marker),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_frame_end(rsp_frame_end),
      .rsp_key_frame(rsp_key_frame),
      .rsp_last_result(rsp_last_result),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   h264_rtp_depacketizer_checker #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload_byte(req_payload_byte),
      .req_bytes_left(req_bytes_left),
      .req_frame_marker(req_frame_marker),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_frame_end(rsp_frame_end),
      .rsp_key_frame(rsp_key_frame),
      .rsp_last_result(rsp_last_result),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .pready(pready),
      .paddr(paddr),
      .pwdata(pwdata),
      .words_open(words_open),
      .mismatch_count(mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run with CHECKS FAILED once cycle_count reaches CYCLE_LIMIT.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Stream side. After each word taken, draw a random stall (none when rx_quiet).
   // A hold request from the stimulus freezes the output for a long stretch,
   // so the block backs up and raises req_stall.
   initial begin
      int rx_gap;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            rx_gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (rx_gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // One payload word. Valid stays high across back-to-back words; it drops only
   // for a drawn idle gap or in wait_idle. Called at a rising edge.
   task automatic send_word(input logic [7:0] b, input logic [11:0] left,
                            input logic marker);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= b;
      req_bytes_left   <= left;
      req_frame_marker <= marker;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Send pkt with bytes_left counting down to 1. A nonzero offset lifts every
   // count (so none reaches 1, and no packet end); drop cuts the tail off.
   task automatic send_packet(input logic marker, input int offset, input int drop);
      int n;
      n = pkt.size();
      for (int i = 0; i < n - drop; i++)
         send_word(pkt[i], 12'(n - i + offset), marker);
   endtask

   // Mostly clean packets; now and then a lifted count or a truncated packet,
   // which leaves the parser mid-packet for whatever follows.
   task automatic send_shaped(input logic marker);
      int offset;
      int drop;
      offset = 0;
      drop = 0;
      if ($urandom_range(0, 9) == 0)
         offset = $urandom_range(2040, 4095 - pkt.size());
      if (pkt.size() > 1 && $urandom_range(0, 19) == 0)
         drop = $urandom_range(1, pkt.size() - 1);
      send_packet(marker, offset, drop);
   endtask

   // zeros are common so start-code look-alikes show up in the data
   function automatic logic [7:0] fill_byte();
      return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      pkt.insert(pkt.size(), b);
   endfunction

   function automatic void add_fill(input int n);
      repeat (n) add_byte(fill_byte());
   endfunction

   function automatic void start_nal(input logic [4:0] nal_type);
      pkt.delete();
      add_byte({3'($urandom_range(0, 7)), nal_type});
   endfunction

   // single-NAL types, IDR favored so key frames are frequent
   function automatic logic [4:0] pick_type();
      return ($urandom_range(0, 2) == 0) ? NAL_IDR : 5'($urandom_range(1, 23));
   endfunction

   function automatic logic [4:0] pick_other_type();
      case ($urandom_range(0, 4))
         0: return NAL_UNSPEC0;
         1: return NAL_MTAP16;
         2: return NAL_MTAP24;
         3: return NAL_RSVD30;
         default: return NAL_RSVD31;
      endcase
   endfunction

   // STAP-A/B with 1..3 units. Malformed ones carry zero, oversized or random
   // lengths and may end with a 1-2 byte stub where a length would start.
   function automatic void build_stap(input logic stap_b, input logic malformed);
      int units;
      int usize;
      int stated;
      start_nal(stap_b ? NAL_STAP_B : NAL_STAP_A);
      if (stap_b)
         add_fill(DON_BYTES);
      units = $urandom_range(1, 3);
      repeat (units) begin
         usize = $urandom_range(1, 5);
         stated = usize;
         if (malformed) begin
            case ($urandom_range(0, 2))
               0: stated = 0;
               1: stated = usize + $urandom_range(1, 400);
               default: stated = $urandom_range(0, 65535);
            endcase
         end
         add_byte(8'(stated >> 8));
         add_byte(8'(stated));
         add_byte({3'($urandom_range(0, 7)), pick_type()});
         add_fill(usize - 1);
      end
      if (malformed && $urandom_range(0, 1) == 1)
         add_fill($urandom_range(1, 2));
   endfunction

   // One H.264 frame or fragment of one. Well-formed structures dominate;
   // the rest is odd types, short FU, malformed STAP and raw noise words.
   task automatic send_h264_frame();
      int         kind;
      int         frags;
      logic [4:0] inner;
      logic       fu_b;
      logic       marker;
      kind = $urandom_range(0, 9);
      marker = ($urandom_range(0, 2) == 0);
      fu_b = 1'($urandom_range(0, 1));
      case (kind)
         0, 1, 2: begin
            start_nal(pick_type());
            add_fill($urandom_range(0, 8));
            send_shaped(marker);
         end
         3, 4: begin
            inner = pick_type();
            frags = $urandom_range(1, 4);
            for (int f = 0; f < frags; f++) begin
               start_nal(fu_b ? NAL_FU_B : NAL_FU_A);
               add_byte({f == 0, f == frags - 1, 1'($urandom_range(0, 1)), inner});
               if (fu_b)
                  add_fill(DON_BYTES);
               add_fill($urandom_range(0, 6));
               send_shaped(marker && f == frags - 1);
            end
         end
         5, 6: begin
            build_stap(fu_b, 1'b0);
            send_shaped(marker);
         end
         7: begin
            build_stap(fu_b, 1'b1);
            send_shaped(marker);
         end
         8: begin
            if ($urandom_range(0, 1) == 1) begin
               start_nal(pick_other_type());
               add_fill($urandom_range(0, 5));
            end else begin
               start_nal(fu_b ? NAL_FU_B : NAL_FU_A);   // FU with no header byte
            end
            send_shaped(marker);
         end
         default: begin
            repeat ($urandom_range(1, 4))
               send_word(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                         1'($urandom_range(0, 1)));
         end
      endcase
   endtask

   // Pass-through modes. MPEG-4 data leans on 00/01/20 so VOL start codes
   // appear, also split across packets and words.
   task automatic send_pass_frame(input logic [1:0] mode_now);
      int n;
      pkt.delete();
      n = $urandom_range(1, 10);
      repeat (n) begin
         if (mode_now == MODE_MPEG4) begin
            case ($urandom_range(0, 5))
               0, 1: add_byte(8'h00);
               2: add_byte(8'h01);
               3: add_byte(MPEG4_VOL);
               default: add_byte(8'($urandom_range(0, 255)));
            endcase
         end else begin
            add_byte(8'($urandom_range(0, 255)));
         end
      end
      if (mode_now == MODE_MPEG4 && $urandom_range(0, 2) == 0) begin
         add_byte(8'h00);
         add_byte(8'h00);
         add_byte(8'h01);
         add_byte(MPEG4_VOL);
      end
      send_shaped($urandom_range(0, 4) < 2);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high.
   task automatic csr_write_mode(input logic [1:0] mode_now);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MODE_ADDR;
      pwdata  <= {30'd0, mode_now};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Sender stops until every predicted word is out, then lets a payload word
   // that gives no output clear the two pipeline stages. The first edge lets
   // words_open catch up with the last word taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_open != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int         phase_no;
      logic [1:0] mode_now;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      csr_write_mode(MODE_H264);

      // --- directed: H.264 corner cases ---
      pkt = '{8'h65, 8'hFF};                    // IDR single NAL closing a key frame
      send_packet(1'b1, 0, 0);
      pkt = '{8'h7C};                           // FU-A without FU header: bare frame end
      send_packet(1'b1, 0, 0);
      pkt = '{8'h7C, 8'h85, 8'h00};             // FU-A start, IDR inside
      send_packet(1'b0, 0, 0);
      pkt = '{8'h7C, 8'h45, 8'hAB};             // FU-A end
      send_packet(1'b1, 0, 0);
      // STAP-A: zero length, one-byte unit, 0xFFFF length clamped to what is left
      pkt = '{8'h18, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'hFF, 8'hFF, 8'h41, 8'h42};
      send_packet(1'b0, 0, 0);
      pkt = '{8'h19, 8'h00};                    // STAP-B too short for its DON
      send_packet(1'b0, 0, 0);
      pkt = '{8'h18, 8'h00, 8'h01};             // STAP-A with a 2-byte length stub
      send_packet(1'b0, 0, 0);
      pkt = '{8'h3D, 8'h81, 8'h12, 8'h34, 8'h80};   // FU-B start, DON dropped
      send_packet(1'b1, 0, 0);
      pkt = '{8'h1F, 8'h00};                    // reserved type, copied as is
      send_packet(1'b0, 0, 0);
      send_word(8'h00, 12'd0, 1'b1);            // bytes_left 0 also ends the packet
      send_word(8'hFF, 12'hFFF, 1'b0);          // bytes_left all ones
      send_word(8'h55, 12'd1, 1'b1);

      // --- random phases: each starts idle, writes codec_mode, sends frames ---
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case (phase_no)
            0: mode_now = MODE_H264;
            1: mode_now = MODE_MPEG4;
            2: mode_now = MODE_PASS;
            3: mode_now = MODE_PASS_ALT;
            default: begin
               case ($urandom_range(0, 5))
                  0, 1, 2: mode_now = MODE_H264;
                  3: mode_now = MODE_MPEG4;
                  4: mode_now = MODE_PASS;
                  default: mode_now = MODE_PASS_ALT;
               endcase
            end
         endcase
         csr_write_mode(mode_now);
         tx_quiet = ($urandom_range(0, 2) == 0);
         rx_quiet = ($urandom_range(0, 2) == 0);
         if (phase_no == 2) begin
            // back-pressure: output frozen while a long packet streams in
            rx_hold_req = 1'b1;
            tx_quiet = 1'b1;
            pkt.delete();
            repeat (40) add_byte(8'($urandom_range(0, 255)));
            send_packet(1'b1, 0, 0);
         end
         repeat ($urandom_range(3, 8)) begin
            if (mode_now == MODE_H264)
               send_h264_frame();
            else
               send_pass_frame(mode_now);
         end
         phase_no++;
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
